// File: hw/rtl/vgl_pkg.sv
// Shared register codes, shape, profile and direction codes, series constants and the series stage record.
package vgl_pkg;

  typedef enum logic [2:0] {
    REG_SHAPE  = 3'd0,
    REG_PROF   = 3'd1,
    REG_DIR    = 3'd2,
    REG_LEVEL  = 3'd3,
    REG_ORIGIN = 3'd4,
    REG_SINK   = 3'd5,
    REG_BOX    = 3'd6,
    REG_RADIUS = 3'd7
  } cfg_reg_t;

  localparam logic [1:0] SHAPE_SINK   = 2'd0;
  localparam logic [1:0] SHAPE_POINT  = 2'd1;
  localparam logic [1:0] SHAPE_CUBOID = 2'd2;

  localparam logic [1:0] PROF_LINEAR = 2'd0;
  localparam logic [1:0] PROF_EXP    = 2'd1;
  localparam logic [1:0] PROF_CONST  = 2'd2;

  localparam logic [2:0] DIR_POS_X = 3'd0;
  localparam logic [2:0] DIR_POS_Y = 3'd1;
  localparam logic [2:0] DIR_POS_Z = 3'd2;
  localparam logic [2:0] DIR_NEG_X = 3'd3;
  localparam logic [2:0] DIR_NEG_Y = 3'd4;
  localparam logic [2:0] DIR_NEG_Z = 3'd5;

  localparam int unsigned WQ_BITS   = 16;
  localparam logic [16:0] W_ONE     = 17'h1_0000;
  localparam int unsigned EXP_TERMS = 13;
  localparam int unsigned EXP_SUBS  = 3;
  localparam logic [30:0] TERM_ONE  = 31'h4000_0000;
  localparam logic [32:0] EXP_ROUND = 33'd8192;

  // One stage of the exponential series pipeline.
  typedef struct packed {
    logic        v;
    logic        app;
    logic [16:0] w;
    logic [30:0] term;
    logic [32:0] sum;
    logic [30:0] p;
    logic [30:0] q;
  } vgl_exp_t;

endpackage

// File: hw/rtl/voxel_gradient_level_unit.sv
// Voxel gradient level unit: protein increment per voxel, fully pipelined.
// This unit takes one voxel beat per clock while the output is not stalled, and returns
// one result beat per voxel, in order, through one front stage, two multiply stages, a classify
// stage, 16 divider stages of one quotient bit each, 39 stages of the 13-term exponential
// series at three stages per term, one multiply stage and the output register. The whole
// pipeline advances together whenever the output register is empty or being taken, so a
// stall on the result side holds every stage in place and nothing is lost or repeated.
// Configuration is written through the cfg port and must only change while the pipeline
// holds no voxel.
module voxel_gradient_level_unit
  import vgl_pkg::*;
#(
  parameter int unsigned COORD_BITS = 10,
  localparam int unsigned CFG_W = (3 * COORD_BITS > 32) ? 3 * COORD_BITS : 32,
  localparam int unsigned IN_W  = ((3 * COORD_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  // in_tdata: vox_x, vox_y, vox_z (COORD_BITS each, lowest first), zero padded.
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  // in_tuser: in_vessel.
  input  logic             in_tuser,
  // out_tdata: level_increment (unsigned Q16.16).
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,
  // out_tuser: applied.
  output logic             out_tuser,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned NW  = 3 * (C + 2);
  localparam int unsigned N2W = 2 * (C + 2);
  localparam int unsigned DW  = 3 * C;
  localparam int unsigned D2W = 2 * C;
  localparam int unsigned RW  = DW + 1;
  localparam int unsigned XS  = EXP_TERMS * EXP_SUBS;

  // Configuration registers.
  logic [1:0]     shape_r;
  logic [1:0]     prof_r;
  logic [2:0]     dir_r;
  logic [31:0]    level_r;
  logic [3*C-1:0] origin_r;
  logic [3*C-1:0] sink_r;
  logic [3*C-1:0] box_r;
  logic [C-1:0]   radius_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r  <= '0;
      prof_r   <= '0;
      dir_r    <= '0;
      level_r  <= '0;
      origin_r <= '0;
      sink_r   <= '0;
      box_r    <= '0;
      radius_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SHAPE:  shape_r  <= cfg_data[1:0];
        REG_PROF:   prof_r   <= cfg_data[1:0];
        REG_DIR:    dir_r    <= cfg_data[2:0];
        REG_LEVEL:  level_r  <= cfg_data[31:0];
        REG_ORIGIN: origin_r <= cfg_data[3*C-1:0];
        REG_SINK:   sink_r   <= cfg_data[3*C-1:0];
        REG_BOX:    box_r    <= cfg_data[3*C-1:0];
        REG_RADIUS: radius_r <= cfg_data[C-1:0];
        default: ;
      endcase
    end
  end

  // Every stage moves when the output register can take a new beat.
  logic pipe_en;
  logic out_v_r;
  assign pipe_en   = !out_v_r || out_tready;
  assign in_tready = pipe_en;

  // ---------------- Front stage: per-axis factors ----------------
  // Source-to-sink and point shapes give a factor (span - d) over span per varying axis;
  // the cuboid ramp puts its numerator and box size on axis 0 and ones elsewhere.
  logic [C-1:0]        vox_a  [3];
  logic [C-1:0]        org_a  [3];
  logic [C-1:0]        snk_a  [3];
  logic [C-1:0]        box_a  [3];
  logic [C-1:0]        dist_a [3];
  logic [C-1:0]        sdist_a[3];
  logic [C-1:0]        span_a [3];
  logic                skip_a [3];
  logic signed [C+1:0] nf_nxt [3];
  logic [C-1:0]        df_nxt [3];
  logic [1:0]          cub_ax;
  logic                cub_dec;
  logic [C-1:0]        cub_v;
  logic [C-1:0]        cub_o;
  logic [C-1:0]        cub_size;
  logic [C-1:0]        cub_half;
  logic signed [C+1:0] cub_num;
  logic                shape_ok;
  logic                app_nxt;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      vox_a[a]   = in_tdata[a*C +: C];
      org_a[a]   = origin_r[a*C +: C];
      snk_a[a]   = sink_r[a*C +: C];
      box_a[a]   = box_r[a*C +: C];
      dist_a[a]  = (vox_a[a] > org_a[a]) ? vox_a[a] - org_a[a] : org_a[a] - vox_a[a];
      sdist_a[a] = (snk_a[a] > org_a[a]) ? snk_a[a] - org_a[a] : org_a[a] - snk_a[a];
      span_a[a]  = (shape_r == SHAPE_POINT) ? radius_r : sdist_a[a];
      skip_a[a]  = (org_a[a] == snk_a[a]) || (dist_a[a] == '0) || (span_a[a] == '0);
    end

    unique case (dir_r)
      DIR_POS_X, DIR_NEG_X: cub_ax = 2'd0;
      DIR_POS_Y, DIR_NEG_Y: cub_ax = 2'd1;
      DIR_POS_Z, DIR_NEG_Z: cub_ax = 2'd2;
      default:              cub_ax = 2'd0;
    endcase
    cub_dec  = (dir_r >= DIR_NEG_X);
    cub_v    = vox_a[cub_ax];
    cub_o    = org_a[cub_ax];
    cub_size = box_a[cub_ax];
    cub_half = cub_size - (cub_size >> 1);
    if (cub_dec) begin
      cub_num = $signed({2'b00, cub_o}) - $signed({2'b00, cub_v}) + $signed({2'b00, cub_half});
    end else begin
      cub_num = $signed({2'b00, cub_v}) - $signed({2'b00, cub_o}) + $signed({2'b00, cub_half});
    end

    for (int a = 0; a < 3; a++) begin
      if (shape_r == SHAPE_CUBOID) begin
        nf_nxt[a] = (C+2)'(1);
        df_nxt[a] = C'(1);
      end else if (skip_a[a]) begin
        nf_nxt[a] = (C+2)'(1);
        df_nxt[a] = C'(1);
      end else begin
        nf_nxt[a] = $signed({2'b00, span_a[a]}) - $signed({2'b00, dist_a[a]});
        df_nxt[a] = span_a[a];
      end
    end
    // A zero box size gives full weight: one over one.
    if (shape_r == SHAPE_CUBOID && cub_size != '0) begin
      nf_nxt[0] = cub_num;
      df_nxt[0] = cub_size;
    end

    shape_ok = (shape_r == SHAPE_SINK) || (shape_r == SHAPE_POINT) ||
               ((shape_r == SHAPE_CUBOID) && (dir_r <= DIR_NEG_Z));
    app_nxt  = !in_tuser && ((prof_r == PROF_CONST) ||
               (((prof_r == PROF_LINEAR) || (prof_r == PROF_EXP)) && shape_ok));
  end

  logic                f_v_r;
  logic                f_app_r;
  logic signed [C+1:0] f_nf_r[3];
  logic [C-1:0]        f_df_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (pipe_en) begin
      f_v_r   <= in_tvalid;
      f_app_r <= app_nxt;
      f_nf_r  <= nf_nxt;
      f_df_r  <= df_nxt;
    end
  end

  // ---------------- Products of the three factors ----------------
  logic                 m_v_r;
  logic                 m_app_r;
  logic signed [N2W-1:0] m_n01_r;
  logic [D2W-1:0]       m_d01_r;
  logic signed [C+1:0]  m_n2_r;
  logic [C-1:0]         m_d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (pipe_en) begin
      m_v_r   <= f_v_r;
      m_app_r <= f_app_r;
      m_n01_r <= N2W'(f_nf_r[0]) * N2W'(f_nf_r[1]);
      m_d01_r <= D2W'(f_df_r[0]) * D2W'(f_df_r[1]);
      m_n2_r  <= f_nf_r[2];
      m_d2_r  <= f_df_r[2];
    end
  end

  logic                 t_v_r;
  logic                 t_app_r;
  logic signed [NW-1:0] t_num_r;
  logic [DW-1:0]        t_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r <= 1'b0;
    end else if (pipe_en) begin
      t_v_r   <= m_v_r;
      t_app_r <= m_app_r;
      t_num_r <= NW'(m_n01_r) * NW'(m_n2_r);
      t_den_r <= DW'(m_d01_r) * DW'(m_d2_r);
    end
  end

  // ---------------- Clamp and restoring divider ----------------
  // Entry 0 is the classify stage; entries 1..16 each settle one quotient bit.
  logic                dv_v_r   [WQ_BITS+1];
  logic                dv_app_r [WQ_BITS+1];
  logic                dv_triv_r[WQ_BITS+1];
  logic [16:0]         dv_wfix_r[WQ_BITS+1];
  logic [DW-1:0]       dv_rem_r [WQ_BITS+1];
  logic [DW-1:0]       dv_den_r [WQ_BITS+1];
  logic [WQ_BITS-1:0]  dv_q_r   [WQ_BITS+1];

  logic num_pos;
  logic num_big;
  assign num_pos = (t_num_r > $signed(NW'(0)));
  assign num_big = (t_num_r >= $signed({{(NW-DW){1'b0}}, t_den_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (pipe_en) begin
      dv_v_r[0]    <= t_v_r;
      dv_app_r[0]  <= t_app_r;
      dv_triv_r[0] <= !num_pos || num_big;
      dv_wfix_r[0] <= num_pos ? W_ONE : 17'd0;
      dv_rem_r[0]  <= t_num_r[DW-1:0];
      dv_den_r[0]  <= t_den_r;
      dv_q_r[0]    <= '0;
    end
  end

  for (genvar i = 1; i <= WQ_BITS; i++) begin : g_div
    logic [RW-1:0] rem2;
    logic [RW-1:0] diff;
    logic          ge;
    assign rem2 = {dv_rem_r[i-1], 1'b0};
    assign diff = rem2 - {1'b0, dv_den_r[i-1]};
    assign ge   = (rem2 >= {1'b0, dv_den_r[i-1]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[i] <= 1'b0;
      end else if (pipe_en) begin
        dv_v_r[i]    <= dv_v_r[i-1];
        dv_app_r[i]  <= dv_app_r[i-1];
        dv_triv_r[i] <= dv_triv_r[i-1];
        dv_wfix_r[i] <= dv_wfix_r[i-1];
        dv_rem_r[i]  <= ge ? diff[DW-1:0] : rem2[DW-1:0];
        dv_den_r[i]  <= dv_den_r[i-1];
        dv_q_r[i]    <= {dv_q_r[i-1][WQ_BITS-2:0], ge};
      end
    end
  end

  // ---------------- Exponential series ----------------
  // Each term takes three stages: multiply by w, multiply by the reciprocal of k,
  // then correct the quotient by one and add the term into the running sum.
  vgl_exp_t ex_r  [XS];
  vgl_exp_t ex_in [XS];
  vgl_exp_t ex_head;

  always_comb begin
    ex_head      = '0;
    ex_head.v    = dv_v_r[WQ_BITS];
    ex_head.app  = dv_app_r[WQ_BITS];
    ex_head.w    = dv_triv_r[WQ_BITS] ? dv_wfix_r[WQ_BITS] : {1'b0, dv_q_r[WQ_BITS]};
    ex_head.term = TERM_ONE;
    ex_head.sum  = {2'b00, TERM_ONE};
  end

  assign ex_in[0] = ex_head;
  for (genvar j = 1; j < XS; j++) begin : g_link
    assign ex_in[j] = ex_r[j-1];
  end

  for (genvar k = 1; k <= EXP_TERMS; k++) begin : g_term
    localparam int unsigned B = (k - 1) * EXP_SUBS;
    localparam logic [31:0] RECIP = (k == 1) ? 32'd0 : 32'((64'd1 << 32) / k);
    localparam logic [30:0] KV = 31'(k);

    vgl_exp_t      s0_nxt, s1_nxt, s2_nxt;
    logic [47:0]   tw_prod;
    logic [62:0]   rc_prod;
    logic [30:0]   resid;

    always_comb begin
      s0_nxt   = ex_in[B];
      tw_prod  = 48'(ex_in[B].term) * 48'(ex_in[B].w);
      s0_nxt.p = tw_prod[46:16];

      s1_nxt   = ex_in[B+1];
      rc_prod  = 63'(ex_in[B+1].p) * 63'(RECIP);
      s1_nxt.q = (k == 1) ? ex_in[B+1].p : rc_prod[62:32];

      s2_nxt   = ex_in[B+2];
      resid    = ex_in[B+2].p - 31'(ex_in[B+2].q * KV);
      s2_nxt.term = (resid >= KV) ? ex_in[B+2].q + 31'd1 : ex_in[B+2].q;
      s2_nxt.sum  = ex_in[B+2].sum + {2'b00, s2_nxt.term};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ex_r[B].v   <= 1'b0;
        ex_r[B+1].v <= 1'b0;
        ex_r[B+2].v <= 1'b0;
      end else if (pipe_en) begin
        ex_r[B]   <= s0_nxt;
        ex_r[B+1] <= s1_nxt;
        ex_r[B+2] <= s2_nxt;
      end
    end
  end

  // ---------------- Scale by the base level ----------------
  logic [32:0] sum_rnd;
  logic [18:0] exp_val;
  logic [18:0] factor;

  assign sum_rnd = ex_r[XS-1].sum + EXP_ROUND;
  assign exp_val = sum_rnd[32:14];

  always_comb begin
    unique case (prof_r)
      PROF_LINEAR: factor = {2'b00, ex_r[XS-1].w};
      PROF_EXP:    factor = exp_val;
      PROF_CONST:  factor = {2'b00, W_ONE};
      default:     factor = '0;
    endcase
  end

  logic        pm_v_r;
  logic        pm_app_r;
  logic [50:0] pm_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_v_r <= 1'b0;
    end else if (pipe_en) begin
      pm_v_r    <= ex_r[XS-1].v;
      pm_app_r  <= ex_r[XS-1].app;
      pm_prod_r <= 51'(level_r) * 51'(factor);
    end
  end

  // ---------------- Output register ----------------
  logic [31:0] inc_nxt;
  logic [31:0] out_inc_r;
  logic        out_app_r;

  always_comb begin
    if (!pm_app_r) begin
      inc_nxt = '0;
    end else if (pm_prod_r[50:48] != 3'd0) begin
      inc_nxt = '1;
    end else begin
      inc_nxt = pm_prod_r[47:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (pipe_en) begin
      out_v_r   <= pm_v_r;
      out_inc_r <= inc_nxt;
      out_app_r <= pm_app_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_inc_r;
  assign out_tuser  = out_app_r;

endmodule

// File: verif/voxel_gradient_level_unit_tb.sv
// Self-checking testbench for the voxel gradient level unit.
`timescale 1ns / 100ps

module voxel_gradient_level_unit_tb
  import vgl_pkg::*;
();

  localparam int unsigned CB = 10;
  localparam int unsigned WATCH_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 80;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  typedef struct packed {
    logic [31:0] level;
    logic        applied;
  } increment_t;

  // The testbench's own copy of the gradient registers.
  logic [1:0]  m_shape;
  logic [1:0]  m_prof;
  logic [2:0]  m_dir;
  logic [31:0] m_level;
  logic [29:0] m_origin;
  logic [29:0] m_sink;
  logic [29:0] m_box;
  logic [9:0]  m_radius;

  increment_t pending_increments[$];
  int unsigned fail_count;
  int unsigned idle_cycles;
  bit          hold_off;
  bit          gaps_on;
  bit          stalls_on;

  voxel_gradient_level_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Clamp num/den to Q1.16; den is always positive here.
  function automatic logic [16:0] ratio_q16(longint num, longint den);
    if (num <= 0) return 17'd0;
    if (num >= den) return W_ONE;
    return 17'((num << 16) / den);
  endfunction

  // e^w in Q16.16 by a truncated Taylor series in Q2.30.
  function automatic logic [63:0] exp_q16(logic [16:0] w);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    x = 64'(w) << 14;
    term = 64'd1 << 30;
    sum = term;
    for (int k = 1; k <= 13; k++) begin
      term = ((term * x) >> 30) / k;
      sum += term;
    end
    return (sum + 64'd8192) >> 14;
  endfunction

  function automatic longint axis_of(logic [29:0] v, int a);
    return longint'((v >> (a * CB)) & 30'h3FF);
  endfunction

  function automatic increment_t gradient_increment(logic [29:0] vox, logic vessel);
    increment_t  r;
    logic [16:0] w;
    logic [63:0] prod;
    longint num, den, o, s, d, span, size, half;
    int ax;
    bit defined;
    r = '0;
    w = '0;
    defined = 1'b0;
    if (vessel) return r;
    if (m_prof == PROF_CONST) begin
      r.level = m_level;
      r.applied = 1'b1;
      return r;
    end
    if (m_prof == 2'd3) return r;
    if (m_shape == SHAPE_SINK || m_shape == SHAPE_POINT) begin
      num = 1;
      den = 1;
      for (int a = 0; a < 3; a++) begin
        o = axis_of(m_origin, a);
        s = axis_of(m_sink, a);
        if (o != s) begin
          d = axis_of(vox, a) - o;
          if (d < 0) d = -d;
          span = (m_shape == SHAPE_SINK) ? ((s > o) ? s - o : o - s) : longint'(m_radius);
          if (d != 0 && span != 0) begin
            num *= span - d;
            den *= span;
          end
        end
      end
      w = ratio_q16(num, den);
      defined = 1'b1;
    end else if (m_shape == SHAPE_CUBOID && m_dir <= DIR_NEG_Z) begin
      ax = m_dir % 3;
      size = axis_of(m_box, ax);
      defined = 1'b1;
      if (size == 0) begin
        w = W_ONE;
      end else begin
        half = size - size / 2;
        o = axis_of(m_origin, ax);
        num = (m_dir < DIR_NEG_X) ? axis_of(vox, ax) - o + half : o - axis_of(vox, ax) + half;
        w = ratio_q16(num, size);
      end
    end
    if (!defined) return r;
    if (m_prof == PROF_LINEAR) prod = (64'(m_level) * 64'(w)) >> 16;
    else prod = (64'(m_level) * exp_q16(w)) >> 16;
    r.level = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
    r.applied = 1'b1;
    return r;
  endfunction

  // Result checker: every accepted result beat is matched against the oldest prediction.
  always @(posedge clk) begin
    increment_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_increments.size() == 0) begin
        $error("unexpected result beat: level %h applied %b", out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = pending_increments.pop_front();
        if (out_tdata !== want.level) begin
          $error("level_increment: expected %h, got %h", want.level, out_tdata);
          fail_count++;
        end
        if (out_tuser !== want.applied) begin
          $error("applied: expected %b, got %b", want.applied, out_tuser);
          fail_count++;
        end
      end
    end
  end

  // The receiver stalls on its own pattern, or holds off completely while asked to.
  always @(negedge clk) begin
    if (!rst_n || hold_off) out_tready <= 1'b0;
    else if (!stalls_on) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 9) > 2);
  end

  // Watchdog: any cycle outside reset and hold-off with no beat accepted on any channel counts toward the limit.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || hold_off || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Writes one register; the valid drops for a cycle before the next write can start.
  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SHAPE:  m_shape = val[1:0];
      REG_PROF:   m_prof = val[1:0];
      REG_DIR:    m_dir = val[2:0];
      REG_LEVEL:  m_level = val;
      REG_ORIGIN: m_origin = val[29:0];
      REG_SINK:   m_sink = val[29:0];
      REG_BOX:    m_box = val[29:0];
      default:    m_radius = val[9:0];
    endcase
    @(negedge clk);
  endtask

  // Sends one voxel beat; the valid stays high between back-to-back beats.
  task automatic send_voxel(logic [9:0] x, logic [9:0] y, logic [9:0] z, logic vessel);
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, z, y, x};
    in_tuser <= vessel;
    do @(posedge clk); while (!in_tready);
    pending_increments = {pending_increments, gradient_increment({z, y, x}, vessel)};
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic end_burst();
    in_tvalid <= 1'b0;
  endtask

  // Waits for every prediction to be met, then for the pipeline depth.
  task automatic drain();
    end_burst();
    while (pending_increments.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_random_voxel();
    send_voxel(10'($urandom), 10'($urandom), 10'($urandom), ($urandom_range(0, 7) == 0));
  endtask

  // Voxels near the configured origin, so the weight stays away from its clamps.
  task automatic send_near_origin();
    logic [9:0] c[3];
    for (int a = 0; a < 3; a++)
      c[a] = 10'(axis_of(m_origin, a) + longint'($urandom_range(0, 64)) - 32);
    send_voxel(c[0], c[1], c[2], ($urandom_range(0, 9) == 0));
  endtask

  task automatic test_directed();
    write_reg(REG_LEVEL, 32'h0001_0000);
    write_reg(REG_ORIGIN, 32'({10'd100, 10'd200, 10'd300}));
    write_reg(REG_SINK, 32'({10'd100, 10'd400, 10'd0}));
    write_reg(REG_RADIUS, 32'(10'd150));
    send_voxel(10'd300, 10'd200, 10'd100, 1'b0);
    send_voxel(10'd0, 10'd0, 10'd0, 1'b0);
    send_voxel(10'h3FF, 10'h3FF, 10'h3FF, 1'b0);
    send_voxel(10'd250, 10'd300, 10'd5, 1'b0);
    send_voxel(10'd250, 10'd300, 10'd5, 1'b1);
    drain();
    write_reg(REG_SHAPE, 32'(SHAPE_POINT));
    write_reg(REG_PROF, 32'(PROF_EXP));
    send_voxel(10'd290, 10'd210, 10'd100, 1'b0);
    send_voxel(10'd300, 10'd200, 10'd100, 1'b0);
    send_voxel(10'd600, 10'd200, 10'd100, 1'b0);
    drain();
    write_reg(REG_RADIUS, 32'(10'd0));
    send_voxel(10'd290, 10'd210, 10'd100, 1'b0);
    drain();
    write_reg(REG_SHAPE, 32'(SHAPE_CUBOID));
    write_reg(REG_BOX, 32'({10'd31, 10'd20, 10'd0}));
    write_reg(REG_LEVEL, 32'hFFFF_FFFF);
    // Zero box size on the x axis gives full weight and a saturated exponential.
    send_voxel(10'd7, 10'd7, 10'd7, 1'b0);
    drain();
    write_reg(REG_DIR, 32'(DIR_NEG_Y));
    send_voxel(10'd0, 10'd195, 10'd0, 1'b0);
    send_voxel(10'd0, 10'd0, 10'd0, 1'b0);
    drain();
    write_reg(REG_DIR, 32'(3'd6));
    send_voxel(10'd1, 10'd2, 10'd3, 1'b0);
    drain();
    write_reg(REG_DIR, 32'(3'd7));
    write_reg(REG_PROF, 32'(PROF_CONST));
    send_voxel(10'd1, 10'd2, 10'd3, 1'b0);
    send_voxel(10'd1, 10'd2, 10'd3, 1'b1);
    drain();
    write_reg(REG_PROF, 32'(2'd3));
    send_voxel(10'd4, 10'd5, 10'd6, 1'b0);
    drain();
    write_reg(REG_PROF, 32'(PROF_LINEAR));
    write_reg(REG_SHAPE, 32'(2'd3));
    send_voxel(10'd4, 10'd5, 10'd6, 1'b0);
    drain();
  endtask

  // Random settings per phase, with voxels mostly around the origin and some at random.
  task automatic test_random_phases();
    for (int phase = 0; phase < 30; phase++) begin
      write_reg(REG_SHAPE, $urandom_range(0, 3));
      write_reg(REG_PROF, ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2));
      write_reg(REG_DIR, $urandom_range(0, 7));
      write_reg(REG_LEVEL, (phase % 5 == 0) ? 32'hFFFF_FFFF : $urandom);
      write_reg(REG_ORIGIN, $urandom);
      write_reg(REG_SINK, ($urandom_range(0, 3) == 0) ? 32'(m_origin ^ 30'h3FF) : $urandom);
      write_reg(REG_BOX, (phase % 7 == 0) ? 32'h3FFF_FFFF : $urandom_range(0, 32'h3FFF_FFFF));
      write_reg(REG_RADIUS, $urandom_range(0, 1023));
      gaps_on = (phase % 4 != 1);
      stalls_on = (phase % 4 != 2);
      for (int i = 0; i < 55; i++) begin
        if ($urandom_range(0, 3) == 0) send_random_voxel();
        else send_near_origin();
      end
      drain();
    end
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall the input.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 100; i++) send_near_origin();
    join
    drain();
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_SHAPE;
    cfg_data = '0;
    hold_off = 1'b0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    fail_count = 0;
    idle_cycles = 0;
    m_shape = '0;
    m_prof = '0;
    m_dir = '0;
    m_level = '0;
    m_origin = '0;
    m_sink = '0;
    m_box = '0;
    m_radius = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_backpressure();
    test_random_phases();
    drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
